### rtl/rnhe_pkg.sv
`timescale 1ns / 1ps
// rnhe_pkg: shared types and constants of the nearest-hit ray engine
// used by rnhe_ctrl, rnhe_iter, rnhe_dp and the top level

package rnhe_pkg;

  localparam logic [30:0] QMAX       = '1;
  localparam int          ACC_W      = 66;
  localparam int          ITER_STEPS = 32;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_PLANE  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    MUL_TC_X, MUL_TC_Y, MUL_TC_Z,
    MUL_OL_X, MUL_OL_Y, MUL_OL_Z,
    MUL_R2, MUL_TM2,
    MUL_DEN_X, MUL_DEN_Y, MUL_DEN_Z,
    MUL_NUM_X, MUL_NUM_Y, MUL_NUM_Z
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_KIND, ST_MUL, ST_FLUSH, ST_CHECK1, ST_CHECK2,
    ST_ITER, ST_TCALC, ST_UPDATE, ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [30:0]        rad;
  } slot_t;

  typedef struct packed {
    logic     ray_start;
    logic     load_wr;
    logic     rd_en;
    logic     oc_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     check1;
    logic     check2;
    logic     iter_step;
    logic     tcalc;
    logic     update;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       miss1;
    logic       miss2;
  } sts_t;

  typedef struct packed {
    logic start_sqrt;
    logic start_div;
    logic step;
  } iter_ctl_t;

endpackage

### rtl/rnhe_ctrl.sv
`timescale 1ns / 1ps
// rnhe_ctrl: sequencer that walks the slot table for each ray
// depends on rnhe_pkg

module rnhe_ctrl
  import rnhe_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_func,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic [4:0]       active_slots,
  input  sts_t             sts,
  output cmd_t             cmd,
  output logic [CNT_W-1:0] slot_idx
);

  localparam logic [2:0] SPH_LAST = 3'd7;
  localparam logic [2:0] PLN_LAST = 3'd5;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, count;
  logic [2:0]       step_r, step_nxt;
  logic [4:0]       it_r, it_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign count    = (int'(active_slots) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(active_slots);
  assign slot_idx = cnt_r;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    it_nxt    = it_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_func) begin
          cnt_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = (cnt_r == count) ? ST_FINISH : ST_KIND;
      end
      ST_KIND: begin
        step_nxt = '0;
        if (sts.kind == KIND_SPHERE || sts.kind == KIND_PLANE) begin
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ((sts.kind == KIND_SPHERE) ? SPH_LAST : PLN_LAST)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_CHECK1;
      ST_CHECK1: begin
        it_nxt = '0;
        if (sts.miss1) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = (sts.kind == KIND_SPHERE) ? ST_CHECK2 : ST_ITER;
        end
      end
      ST_CHECK2: begin
        it_nxt = '0;
        if (sts.miss2) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        it_nxt = it_r + 1'b1;
        if (it_r == 5'(ITER_STEPS - 1)) begin
          state_nxt = ST_TCALC;
        end
      end
      ST_TCALC: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_READ;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_TC_X;
    case (state_r)
      ST_IDLE: begin
        cmd.ray_start = in_valid && in_func;
        cmd.load_wr   = in_valid && !in_func;
      end
      ST_READ:   cmd.rd_en = (cnt_r != count);
      ST_KIND:   cmd.oc_en = 1'b1;
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (sts.kind == KIND_SPHERE) begin
          case (step_r)
            3'd0:    cmd.mul_sel = MUL_TC_X;
            3'd1:    cmd.mul_sel = MUL_TC_Y;
            3'd2:    cmd.mul_sel = MUL_TC_Z;
            3'd3:    cmd.mul_sel = MUL_OL_X;
            3'd4:    cmd.mul_sel = MUL_OL_Y;
            3'd5:    cmd.mul_sel = MUL_OL_Z;
            3'd6:    cmd.mul_sel = MUL_R2;
            default: cmd.mul_sel = MUL_TM2;
          endcase
        end else begin
          case (step_r)
            3'd0:    cmd.mul_sel = MUL_DEN_X;
            3'd1:    cmd.mul_sel = MUL_DEN_Y;
            3'd2:    cmd.mul_sel = MUL_DEN_Z;
            3'd3:    cmd.mul_sel = MUL_NUM_X;
            3'd4:    cmd.mul_sel = MUL_NUM_Y;
            default: cmd.mul_sel = MUL_NUM_Z;
          endcase
        end
      end
      ST_CHECK1: cmd.check1    = 1'b1;
      ST_CHECK2: cmd.check2    = 1'b1;
      ST_ITER:   cmd.iter_step = 1'b1;
      ST_TCALC:  cmd.tcalc     = 1'b1;
      ST_UPDATE: cmd.update    = 1'b1;
      ST_FINISH: cmd.out_load  = !out_valid_r || !out_stall;
      default:   cmd.out_load  = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

### rtl/rnhe_iter.sv
`timescale 1ns / 1ps
// rnhe_iter: shared bit-serial unit for the half-chord square root and
// the plane distance division; depends on rnhe_pkg

module rnhe_iter
  import rnhe_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  iter_ctl_t   ctl,
  input  logic [62:0] sq_x,
  input  logic [63:0] dv_num,
  input  logic [63:0] dv_den,
  output logic [31:0] root,
  output logic [30:0] quot
);

  logic [95:0] rem_r, dsr_r;
  logic [62:0] bit_r;
  logic [31:0] q_r;
  logic        sqrt_r;
  logic [63:0] trial;
  logic [95:0] cmp_b, diff;
  logic        ge;

  // sqrt keeps the partial root in dsr_r; res and bit never overlap
  assign trial = dsr_r[63:0] | {1'b0, bit_r};
  assign cmp_b = sqrt_r ? {32'b0, trial} : dsr_r;
  assign ge    = (rem_r >= cmp_b);
  assign diff  = rem_r - cmp_b;
  assign root  = dsr_r[31:0];
  assign quot  = q_r[31] ? QMAX : q_r[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqrt_r <= 1'b0;
    end else if (ctl.start_sqrt) begin
      sqrt_r <= 1'b1;
    end else if (ctl.start_div) begin
      sqrt_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_sqrt) begin
      rem_r <= 96'(sq_x);
      dsr_r <= '0;
      bit_r <= 63'(1) << 62;
    end else if (ctl.start_div) begin
      rem_r <= 96'(dv_num) << FRAC_BITS;
      dsr_r <= 96'(dv_den) << 31;
      q_r   <= '0;
    end else if (ctl.step) begin
      if (ge) begin
        rem_r <= diff;
      end
      if (sqrt_r) begin
        dsr_r <= ge ? ((dsr_r >> 1) | {33'b0, bit_r}) : (dsr_r >> 1);
        bit_r <= bit_r >> 2;
      end else begin
        dsr_r <= dsr_r >> 1;
        q_r   <= {q_r[30:0], ge};
      end
    end
  end

endmodule

### rtl/rnhe_dp.sv
`timescale 1ns / 1ps
// rnhe_dp: slot memory, shared multiplier with accumulators, hit checks
// and nearest-hit tracking; depends on rnhe_pkg and rnhe_iter

module rnhe_dp
  import rnhe_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int FRAC_BITS = 16,
  parameter int CNT_W     = $clog2(SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [CNT_W-1:0]   slot_idx,
  output sts_t               sts,
  input  logic [3:0]         in_slot,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_vector_x,
  input  logic signed [31:0] in_vector_y,
  input  logic signed [31:0] in_vector_z,
  input  logic [30:0]        in_sphere_radius,
  input  logic [30:0]        in_t_limit,
  output logic               out_found,
  output logic [30:0]        out_nearest_distance,
  output logic [3:0]         out_nearest_slot
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic signed [32:0] SAT_HI = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] SAT_LO = -SAT_HI;

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d > SAT_HI)      sat_sub = SAT_HI[31:0];
    else if (d < SAT_LO) sat_sub = SAT_LO[31:0];
    else                 sat_sub = d[31:0];
  endfunction

  slot_t mem [SLOTS];
  slot_t rd_q_r;

  logic signed [31:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;
  logic signed [31:0] ocx_r, ocy_r, ocz_r;
  logic [30:0]        lim_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod, p_r;
  logic               p_vld_r;
  mul_sel_t           p_sel_r;
  logic signed [ACC_W-1:0] acc_a_r, acc_b_r, p_ext, chord;
  logic [ACC_W-1:0]   tc_mag, num_mag, den_mag, tm_full;
  logic [61:0]        r2_r, tm2_r;
  logic [62:0]        sum_r;
  logic [30:0]        tm;
  logic signed [33:0] tq, a34, t1, t2;
  logic [30:0]        t_nxt, t_r, best_r;
  logic               ok_nxt, t_ok_r, found_r;
  logic [3:0]         best_slot_r;
  logic [31:0]        root;
  logic [30:0]        quot;
  iter_ctl_t          ictl;
  logic               out_found_r;
  logic [30:0]        out_dist_r;
  logic [3:0]         out_slot_r;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (int'(in_slot) < SLOTS)) begin
      mem[AW'(in_slot)] <= '{kind: in_kind, px: in_point_x, py: in_point_y, pz: in_point_z,
                             vx: in_vector_x, vy: in_vector_y, vz: in_vector_z,
                             rad: in_sphere_radius};
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[slot_idx[AW-1:0]];
    end
  end

  // closest-approach distance along the ray, truncated and saturated
  assign tc_mag  = acc_a_r[ACC_W-1] ? ACC_W'(-acc_a_r) : ACC_W'(acc_a_r);
  assign tm_full = tc_mag >> FRAC_BITS;
  assign tm      = (tm_full > ACC_W'(QMAX)) ? QMAX : tm_full[30:0];
  assign num_mag = acc_b_r[ACC_W-1] ? ACC_W'(-acc_b_r) : ACC_W'(acc_b_r);
  assign den_mag = tc_mag;

  always_comb begin
    case (cmd.mul_sel)
      MUL_TC_X:  begin mul_a = ocx_r;            mul_b = dx_r;             end
      MUL_TC_Y:  begin mul_a = ocy_r;            mul_b = dy_r;             end
      MUL_TC_Z:  begin mul_a = ocz_r;            mul_b = dz_r;             end
      MUL_OL_X:  begin mul_a = ocx_r;            mul_b = ocx_r;            end
      MUL_OL_Y:  begin mul_a = ocy_r;            mul_b = ocy_r;            end
      MUL_OL_Z:  begin mul_a = ocz_r;            mul_b = ocz_r;            end
      MUL_R2:    begin mul_a = {1'b0, rd_q_r.rad}; mul_b = {1'b0, rd_q_r.rad}; end
      MUL_TM2:   begin mul_a = {1'b0, tm};       mul_b = {1'b0, tm};       end
      MUL_DEN_X: begin mul_a = rd_q_r.vx;        mul_b = dx_r;             end
      MUL_DEN_Y: begin mul_a = rd_q_r.vy;        mul_b = dy_r;             end
      MUL_DEN_Z: begin mul_a = rd_q_r.vz;        mul_b = dz_r;             end
      MUL_NUM_X: begin mul_a = rd_q_r.vx;        mul_b = ocx_r;            end
      MUL_NUM_Y: begin mul_a = rd_q_r.vy;        mul_b = ocy_r;            end
      MUL_NUM_Z: begin mul_a = rd_q_r.vz;        mul_b = ocz_r;            end
      default:   begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign p_ext = ACC_W'(p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= prod;
    p_sel_r <= cmd.mul_sel;
    if (cmd.oc_en) begin
      ocx_r   <= sat_sub(rd_q_r.px, ox_r);
      ocy_r   <= sat_sub(rd_q_r.py, oy_r);
      ocz_r   <= sat_sub(rd_q_r.pz, oz_r);
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (p_vld_r) begin
      case (p_sel_r)
        MUL_TC_X, MUL_TC_Y, MUL_TC_Z, MUL_DEN_X, MUL_DEN_Y, MUL_DEN_Z:
          acc_a_r <= acc_a_r + p_ext;
        MUL_OL_X, MUL_OL_Y, MUL_OL_Z, MUL_NUM_X, MUL_NUM_Y, MUL_NUM_Z:
          acc_b_r <= acc_b_r + p_ext;
        MUL_R2:  r2_r  <= p_r[61:0];
        MUL_TM2: tm2_r <= p_r[61:0];
        default: r2_r  <= r2_r;
      endcase
    end
    if (cmd.check1) begin
      sum_r <= {1'b0, r2_r} + {1'b0, tm2_r};
    end
  end

  // squared half chord: r^2 + tc^2 - |oc|^2
  assign chord = $signed({3'b0, sum_r}) - acc_b_r;

  always_comb begin
    sts.kind  = rd_q_r.kind;
    sts.miss2 = chord[ACC_W-1];
    if (rd_q_r.kind == KIND_SPHERE) begin
      sts.miss1 = acc_a_r[ACC_W-1] && (acc_b_r > $signed({4'b0, r2_r}));
    end else begin
      sts.miss1 = (acc_a_r == '0) || (acc_b_r == '0) ||
                  (acc_a_r[ACC_W-1] != acc_b_r[ACC_W-1]);
    end
  end

  assign ictl.start_div  = cmd.check1 && (rd_q_r.kind == KIND_PLANE);
  assign ictl.start_sqrt = cmd.check2;
  assign ictl.step       = cmd.iter_step;

  rnhe_iter #(
    .FRAC_BITS(FRAC_BITS)
  ) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ictl),
    .sq_x  (chord[62:0]),
    .dv_num(num_mag[63:0]),
    .dv_den(den_mag[63:0]),
    .root  (root),
    .quot  (quot)
  );

  // sphere takes the near root first, then the far one
  assign tq  = acc_a_r[ACC_W-1] ? -$signed({3'b0, tm}) : $signed({3'b0, tm});
  assign a34 = $signed({2'b0, root});
  assign t1  = tq - a34;
  assign t2  = tq + a34;

  always_comb begin
    t_nxt  = quot;
    ok_nxt = (quot != '0);
    if (rd_q_r.kind == KIND_SPHERE) begin
      if (t1 > 34'sd0) begin
        ok_nxt = 1'b1;
        t_nxt  = (t1 > $signed({3'b0, QMAX})) ? QMAX : t1[30:0];
      end else if (t2 > 34'sd0) begin
        ok_nxt = 1'b1;
        t_nxt  = (t2 > $signed({3'b0, QMAX})) ? QMAX : t2[30:0];
      end else begin
        ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ray_start) begin
      ox_r        <= in_point_x;
      oy_r        <= in_point_y;
      oz_r        <= in_point_z;
      dx_r        <= in_vector_x;
      dy_r        <= in_vector_y;
      dz_r        <= in_vector_z;
      lim_r       <= in_t_limit;
      found_r     <= 1'b0;
      best_r      <= '0;
      best_slot_r <= '0;
    end else if (cmd.update) begin
      if (t_ok_r && (lim_r == QMAX || t_r < lim_r) && (!found_r || t_r < best_r)) begin
        found_r     <= 1'b1;
        best_r      <= t_r;
        best_slot_r <= 4'(slot_idx);
      end
    end
    if (cmd.tcalc) begin
      t_r    <= t_nxt;
      t_ok_r <= ok_nxt;
    end
    if (cmd.out_load) begin
      out_found_r <= found_r;
      out_dist_r  <= best_r;
      out_slot_r  <= best_slot_r;
    end
  end

  assign out_found            = out_found_r;
  assign out_nearest_distance = out_dist_r;
  assign out_nearest_slot     = out_slot_r;

endmodule

### rtl/ray_nearest_hit_engine.sv
`timescale 1ns / 1ps
// ray_nearest_hit_engine: top level of the nearest-hit ray engine
// depends on rnhe_pkg, rnhe_ctrl, rnhe_dp (with rnhe_iter)
//
//   channel  | direction | handshake             | carries
//   ---------+-----------+-----------------------+------------------------------
//   in_      | input     | in_valid / in_stall   | slot load or ray cast
//   out_     | output    | out_valid / out_stall | found, nearest distance, slot
//   cfg      | input     | psel/penable/pready   | active_slots at address 0 to 3
//
// a slot load is a single-cycle transfer and the block stays ready
// a ray walks slots 0 .. active_slots-1 (capped at SLOTS) one at a time; a
// sphere takes 8 multiplies and a 32-step square root, a plane takes 6
// multiplies and a 32-step divide, and an empty slot is skipped
// all multiplies share one 32x32 multiplier; root and divide share one unit
// reset clears the controller, the output valid and active_slots; slot
// contents stay undefined until loaded
// a held result does not block a new transfer in; only the next ray
// result waits on out_stall

module ray_nearest_hit_engine
  import rnhe_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [3:0]         in_slot,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_vector_x,
  input  logic signed [31:0] in_vector_y,
  input  logic signed [31:0] in_vector_z,
  input  logic [30:0]        in_sphere_radius,
  input  logic [30:0]        in_t_limit,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [30:0]        out_nearest_distance,
  output logic [3:0]         out_nearest_slot,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [4:0]       active_r;
  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] slot_idx;

  // register file: only active_slots, at addresses 0 to 3 (paddr[2] low)
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'b0, active_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      active_r <= pwdata[4:0];
    end
  end

  rnhe_ctrl #(
    .SLOTS(SLOTS),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_func     (in_func),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .active_slots(active_r),
    .sts         (sts),
    .cmd         (cmd),
    .slot_idx    (slot_idx)
  );

  rnhe_dp #(
    .SLOTS    (SLOTS),
    .FRAC_BITS(FRAC_BITS),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .slot_idx            (slot_idx),
    .sts                 (sts),
    .in_slot             (in_slot),
    .in_kind             (in_kind),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_point_z          (in_point_z),
    .in_vector_x         (in_vector_x),
    .in_vector_y         (in_vector_y),
    .in_vector_z         (in_vector_z),
    .in_sphere_radius    (in_sphere_radius),
    .in_t_limit          (in_t_limit),
    .out_found           (out_found),
    .out_nearest_distance(out_nearest_distance),
    .out_nearest_slot    (out_nearest_slot)
  );

endmodule

### rtl/rnhe_checker.sv
`timescale 1ns / 1ps
// rnhe_checker: port-level checks of the nearest-hit ray engine
// bound to ray_nearest_hit_engine; no other dependencies

module rnhe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [30:0] out_nearest_distance,
  input logic [3:0]  out_nearest_slot
);

  // a result stalled by the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a miss reports zero distance and slot
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_nearest_distance == 31'd0 && out_nearest_slot == 4'd0)
    else $error("miss with nonzero payload");

  // a hit lies strictly beyond the ray start
  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_nearest_distance != 31'd0)
    else $error("hit at zero distance");

  // a ray transfer makes the engine busy
  a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func |=> in_stall)
    else $error("ray accepted without going busy");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_nearest_hit_engine rnhe_checker u_rnhe_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_func             (in_func),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_found           (out_found),
  .out_nearest_distance(out_nearest_distance),
  .out_nearest_slot    (out_nearest_slot)
);
